FILE: design/u8sv_pkg.sv
`default_nettype none

package u8sv_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_2BYTE   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h010000;

    // per-text decode state of the current span
    typedef struct packed {
        logic [2:0]      bytes_left;
        logic [2:0]      span_length;
        logic [CP_W-1:0] partial_code;
        logic            span_bad;
    } t_span_state;

    typedef struct packed {
        logic            zero_stop;   // zero byte at character start
        logic            lead;        // byte opened a new span
        logic            advance;     // byte counted in the offset
        logic            done;
        logic            err;
        logic [CP_W-1:0] code_point;
    } t_span_result;

    localparam t_span_state SPAN_RESET = '{
        bytes_left:   3'd0,
        span_length:  3'd0,
        partial_code: '0,
        span_bad:     1'b0
    };

    function automatic logic span_invalid(input t_span_state s);
        logic bad;
        bad = s.span_bad;
        if (s.span_length == 3'd2 && s.partial_code < MIN_2BYTE) bad = 1'b1;
        if (s.span_length == 3'd3 && s.partial_code < MIN_3BYTE) bad = 1'b1;
        if (s.span_length == 3'd4 && s.partial_code < MIN_4BYTE) bad = 1'b1;
        if (s.partial_code >= SURR_LO && s.partial_code <= SURR_HI) bad = 1'b1;
        if (s.partial_code > CP_MAX) bad = 1'b1;
        return bad;
    endfunction

endpackage

`default_nettype wire

FILE: design/u8sv_span_dec.sv
`default_nettype none

module u8sv_span_dec (
    input  var u8sv_pkg::t_span_state  i_state,
    input  wire logic [7:0]            i_text_byte,
    input  wire logic                  i_end_of_text,
    output u8sv_pkg::t_span_state      o_state,
    output u8sv_pkg::t_span_result     o_result
);
    import u8sv_pkg::*;

    t_span_state  n_st;
    t_span_result res;

    always_comb begin
        n_st = i_state;
        res  = '0;
        if (i_state.bytes_left == 3'd0) begin
            if (i_text_byte == 8'h00) begin
                res.zero_stop = 1'b1;
            end else begin
                res.lead      = 1'b1;
                res.advance   = 1'b1;
                n_st.span_bad = 1'b0;
                if (i_text_byte < 8'h80) begin
                    n_st.span_length  = 3'd1;
                    n_st.partial_code = {13'd0, i_text_byte};
                end else if (i_text_byte < 8'hC0) begin
                    // stray continuation byte
                    n_st.span_length  = 3'd1;
                    n_st.partial_code = '0;
                    n_st.span_bad     = 1'b1;
                end else if (i_text_byte < 8'hE0) begin
                    n_st.span_length  = 3'd2;
                    n_st.partial_code = {16'd0, i_text_byte[4:0]};
                end else if (i_text_byte < 8'hF0) begin
                    n_st.span_length  = 3'd3;
                    n_st.partial_code = {17'd0, i_text_byte[3:0]};
                end else if (i_text_byte < 8'hF8) begin
                    n_st.span_length  = 3'd4;
                    n_st.partial_code = {18'd0, i_text_byte[2:0]};
                end else if (i_text_byte < 8'hFC) begin
                    n_st.span_length  = 3'd5;
                    n_st.partial_code = '0;
                    n_st.span_bad     = 1'b1;
                end else if (i_text_byte < 8'hFE) begin
                    n_st.span_length  = 3'd6;
                    n_st.partial_code = '0;
                    n_st.span_bad     = 1'b1;
                end else begin
                    n_st.span_length  = 3'd1;
                    n_st.partial_code = '0;
                    n_st.span_bad     = 1'b1;
                end
                n_st.bytes_left = n_st.span_length - 3'd1;
            end
        end else begin
            if (i_text_byte[7:6] != 2'b10) n_st.span_bad = 1'b1;
            n_st.partial_code = {i_state.partial_code[CP_W-7:0], i_text_byte[5:0]};
            n_st.bytes_left   = i_state.bytes_left - 3'd1;
            res.advance       = 1'b1;
        end

        if (res.advance && n_st.bytes_left == 3'd0) begin
            res.done = 1'b1;
            res.err  = span_invalid(n_st);
        end
        // end of text cuts an unfinished span
        if (!res.done && i_end_of_text && n_st.bytes_left != 3'd0) begin
            res.done = 1'b1;
            res.err  = 1'b1;
        end
        res.code_point = (res.done && !res.err) ? n_st.partial_code : '0;
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

`default_nettype wire

FILE: design/utf8_stream_validator.sv
`default_nettype none

// The result of an input transfer is registered and appears on the outputs in the cycle after the transfer.
// Throughput: one byte per cycle while the output is not stalled; the decode
// path is the span decoder plus the span-start select into the result register.
// Reset (synchronous, active low) empties the result register and returns the
// decode state to the start of a text; state also returns there after the
// end-of-text byte.
module utf8_stream_validator #(
    parameter int unsigned OFFSET_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [20:0]      o_code_point,
    output logic             o_char_done,
    output logic             o_char_error,
    output logic [31:0]      o_char_offset,
    output logic             o_text_end,
    output logic             o_text_valid
);
    import u8sv_pkg::*;

    t_span_state  r_span;
    t_span_state  w_span_next;
    t_span_result w_res;

    logic [OFFSET_WIDTH-1:0] r_byte_count;
    logic [OFFSET_WIDTH-1:0] r_span_start;
    logic [OFFSET_WIDTH-1:0] n_span_start;
    logic                    r_stopped;
    logic                    r_all_good;
    logic                    n_all_good;
    logic                    w_accept;
    logic                    w_active;
    logic [31:0]             w_ofs_ext;

    logic                    r_out_valid;
    logic [CP_W-1:0]         r_code_point;
    logic                    r_char_done;
    logic                    r_char_error;
    logic [31:0]             r_char_offset;
    logic                    r_text_end;
    logic                    r_text_valid;

    u8sv_span_dec u_dec (
        .i_state       (r_span),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_state       (w_span_next),
        .o_result      (w_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_active   = !r_stopped;

    always_comb begin
        n_span_start = w_res.lead ? r_byte_count : r_span_start;
        n_all_good   = r_all_good;
        if (w_active && w_res.done && w_res.err) n_all_good = 1'b0;
        w_ofs_ext    = 32'(n_span_start);
    end

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span       <= SPAN_RESET;
            r_byte_count <= '0;
            r_span_start <= '0;
            r_stopped    <= 1'b0;
            r_all_good   <= 1'b1;
        end else if (w_accept) begin
            if (i_end_of_text) begin
                r_span       <= SPAN_RESET;
                r_byte_count <= '0;
                r_span_start <= '0;
                r_stopped    <= 1'b0;
                r_all_good   <= 1'b1;
            end else if (w_active) begin
                r_span       <= w_span_next;
                r_span_start <= n_span_start;
                r_all_good   <= n_all_good;
                if (w_res.advance) r_byte_count <= r_byte_count + OFFSET_WIDTH'(1);
                if (w_res.zero_stop) r_stopped <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_code_point  <= w_active ? w_res.code_point : '0;
            r_char_done   <= w_active && w_res.done;
            r_char_error  <= w_active && w_res.err;
            r_char_offset <= (w_active && w_res.done) ? w_ofs_ext : 32'd0;
            r_text_end    <= i_end_of_text;
            r_text_valid  <= i_end_of_text && (w_active ? n_all_good : r_all_good);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_code_point;
    assign o_char_done   = r_char_done;
    assign o_char_error  = r_char_error;
    assign o_char_offset = r_char_offset;
    assign o_text_end    = r_text_end;
    assign o_text_valid  = r_text_valid;

endmodule

`default_nettype wire
